// ===== rtl/core/multi_axis_bresenham_step_generator_top_assert.svh =====
// Assertion macros shared by the step generator RTL.
`ifndef MULTI_AXIS_BRESENHAM_STEP_GENERATOR_TOP_ASSERT_SVH
`define MULTI_AXIS_BRESENHAM_STEP_GENERATOR_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MBSG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define MBSG_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== rtl/core/mbsg_pkg.sv =====
// Types, constants and helpers of the step generator.
package mbsg_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int AXIS_COUNT  = 7;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int AXIS_W      = 3;
   localparam int MASK_W      = 7;

   localparam logic [7:0]        LAST_DIRS_RESET = 8'd128;
   localparam logic [7:0]        PARENT_NONE     = 8'd255;
   localparam logic [AXIS_W-1:0] ERROR_STEP_SEL  = 3'd7;
   localparam logic              CSR_SLOW_DIR    = 1'b0;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_COMMIT = 2'd1,
      OP_LOAD   = 2'd2
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [MASK_W-1:0]  axis_mask;
      logic [MASK_W-1:0]  directions;
      logic               check_endstops;
      logic               last_of_parent;
      logic [7:0]         parent_id;
      logic [15:0]        step_count;
      logic [7:0]         secondary_value;
      logic [AXIS_W-1:0]  axis_index;
      logic [30:0]        axis_delta;
      logic signed [31:0] axis_error;
      logic               skip_request;
   } req_item_type;

   typedef struct packed {
      logic [MASK_W-1:0] step_mask;
      logic [MASK_W-1:0] direction_mask;
      logic              direction_changed;
      logic              secondary_update;
      logic [7:0]        secondary_out;
      logic              segment_done;
      logic              parent_done;
      logic              idle;
      logic [4:0]        queue_level;
      logic              load_rejected;
   } rsp_item_type;

   typedef struct packed {
      logic [MASK_W-1:0] dirs;
      logic [MASK_W-1:0] used;
      logic              checked;
      logic              last;
      logic [7:0]        parent;
      logic [15:0]       steps;
      logic [7:0]        intensity;
      logic [31:0]       err_step;
   } seg_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - 1'b1;
   endfunction

endpackage

// ===== rtl/core/mbsg_front.sv =====
// Two-entry input queue between the stream slave and the executor.
module mbsg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mbsg_pkg::req_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mbsg_pkg::req_item_type out_item
);
   import mbsg_pkg::*;

   req_item_type mem_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wr_ptr_ff] <= in_item;
   end

endmodule

// ===== rtl/core/mbsg_back.sv =====
// Executor: segment ring, Bresenham axes and result register.
module mbsg_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   slow_dir,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mbsg_pkg::req_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mbsg_pkg::rsp_item_type out_item
);
   import mbsg_pkg::*;

   seg_type     seg_mem [QUEUE_DEPTH];
   logic [31:0] inc_mem [AXIS_COUNT][QUEUE_DEPTH];
   logic [31:0] acc_mem [AXIS_COUNT][QUEUE_DEPTH];

   logic [IDX_W-1:0]  head_ff, tail_ff, head_in, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              active_ff, active_in;
   logic [7:0]        last_dirs_ff, last_dirs_in;
   logic [7:0]        last_parent_ff, last_parent_in;
   logic [7:0]        skip_ff, skip_in;
   logic [MASK_W-1:0] blocked_ff, blocked_in;
   seg_type           act_ff, act_in;
   logic              out_valid_ff;
   rsp_item_type      out_ff, rsp_in;

   seg_type              rd0, rd1, cur;
   logic [IDX_W-1:0]     slot, rd_addr2;
   logic                 fire, do_run, countdown, step_en, nd;
   logic [MASK_W-1:0]    block;
   logic [31:0]          acc_new [AXIS_COUNT];
   logic [AXIS_COUNT-1:0] acc_we;
   logic [31:0]          e_sum;
   logic                 stepv;

   assign in_ready  = !out_valid_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

   assign rd_addr2 = active_ff ? head_ff : next_idx(head_ff);
   assign rd0      = seg_mem[head_ff];
   assign rd1      = seg_mem[rd_addr2];

   always_comb begin
      head_in = head_ff; tail_in = tail_ff; count_in = count_ff;
      active_in = active_ff; last_dirs_in = last_dirs_ff;
      last_parent_in = last_parent_ff; skip_in = skip_ff; blocked_in = blocked_ff;
      act_in = act_ff; rsp_in = '0;
      cur = act_ff; slot = prev_idx(head_ff);
      do_run = 1'b0; countdown = 1'b0; step_en = 1'b0; block = '0; nd = 1'b0;
      e_sum = '0; stepv = 1'b0;
      case (in_item.operation)
         OP_TICK: begin
            if (!active_ff) begin
               if (count_ff != '0) begin
                  nd = (last_dirs_ff != {1'b0, rd0.dirs}) && (rd0.used != '0);
                  head_in   = next_idx(head_ff);
                  active_in = 1'b1;
                  if (rd0.parent != last_parent_ff) begin
                     blocked_in = '0;
                     skip_in    = PARENT_NONE;
                  end
                  if (nd) begin
                     last_dirs_in             = {1'b0, rd0.dirs};
                     rsp_in.direction_changed = 1'b1;
                  end
                  last_parent_in          = rd0.parent;
                  rsp_in.secondary_update = 1'b1;
                  rsp_in.secondary_out    = rd0.intensity;
                  cur    = rd0;
                  act_in = rd0;
                  slot   = head_ff;
                  do_run = !(nd && slow_dir);
               end
            end else begin
               do_run = 1'b1;
            end
            if (do_run) begin
               countdown = 1'b1;
               if (cur.used != '0) begin
                  if (cur.checked) begin
                     if (cur.parent == skip_in) begin
                        // skipped parent: retire now, pull in the next segment
                        countdown           = 1'b0;
                        rsp_in.segment_done = 1'b1;
                        rsp_in.parent_done  = cur.last;
                        count_in            = count_in - 1'b1;
                        if (count_in == '0) begin
                           active_in = 1'b0;
                        end else begin
                           nd = (last_dirs_in != {1'b0, rd1.dirs}) && (rd1.used != '0);
                           head_in = next_idx(rd_addr2);
                           if (rd1.parent != last_parent_in) begin
                              blocked_in = '0;
                              skip_in    = PARENT_NONE;
                           end
                           if (nd) begin
                              last_dirs_in             = {1'b0, rd1.dirs};
                              rsp_in.direction_changed = 1'b1;
                           end
                           last_parent_in          = rd1.parent;
                           rsp_in.secondary_update = 1'b1;
                           rsp_in.secondary_out    = rd1.intensity;
                           act_in                  = rd1;
                        end
                     end else if (in_item.skip_request) begin
                        skip_in   = cur.parent;
                        countdown = 1'b0;
                     end else begin
                        blocked_in = blocked_in | in_item.axis_mask;
                        block      = blocked_in;
                        step_en    = 1'b1;
                     end
                  end else begin
                     step_en = 1'b1;
                  end
               end
               if (countdown) begin
                  act_in.steps = cur.steps - 1'b1;
                  if (act_in.steps == '0) begin
                     rsp_in.segment_done = 1'b1;
                     rsp_in.parent_done  = cur.last;
                     count_in            = count_in - 1'b1;
                     active_in           = 1'b0;
                  end
               end
            end
         end
         OP_COMMIT: begin
            if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
               rsp_in.load_rejected = 1'b1;
            end else begin
               tail_in  = next_idx(tail_ff);
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
      for (int a = 0; a < AXIS_COUNT; a++) begin
         e_sum      = acc_mem[a][slot] + inc_mem[a][slot];
         stepv      = (e_sum != '0) && !e_sum[31];
         acc_new[a] = stepv ? e_sum - cur.err_step : e_sum;
         acc_we[a]  = step_en && !block[a];
         rsp_in.step_mask[a] = acc_we[a] && stepv;
      end
      rsp_in.direction_mask = last_dirs_in[MASK_W-1:0];
      rsp_in.idle           = !active_in && (count_in == '0);
      rsp_in.queue_level    = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0; tail_ff <= '0; count_ff <= '0; active_ff <= 1'b0;
         last_dirs_ff <= LAST_DIRS_RESET; last_parent_ff <= PARENT_NONE;
         skip_ff <= PARENT_NONE; blocked_ff <= '0; out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            head_ff <= head_in; tail_ff <= tail_in; count_ff <= count_in;
            active_ff <= active_in; last_dirs_ff <= last_dirs_in;
            last_parent_ff <= last_parent_in; skip_ff <= skip_in;
            blocked_ff <= blocked_in;
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (fire) begin
         act_ff <= act_in;
         out_ff <= rsp_in;
      end
   end

   // ring and axis storage
   always_ff @(posedge clock) begin
      if (fire && in_item.operation == OP_COMMIT && count_ff < CNT_W'(QUEUE_DEPTH)) begin
         seg_mem[tail_ff].used      <= in_item.axis_mask;
         seg_mem[tail_ff].dirs      <= in_item.directions;
         seg_mem[tail_ff].checked   <= in_item.check_endstops;
         seg_mem[tail_ff].last      <= in_item.last_of_parent;
         seg_mem[tail_ff].parent    <= in_item.parent_id;
         seg_mem[tail_ff].steps     <= in_item.step_count;
         seg_mem[tail_ff].intensity <= in_item.secondary_value;
      end
      if (fire && in_item.operation == OP_LOAD && count_ff < CNT_W'(QUEUE_DEPTH)) begin
         if (in_item.axis_index == ERROR_STEP_SEL) begin
            seg_mem[tail_ff].err_step <= {1'b0, in_item.axis_delta};
         end
         for (int a = 0; a < AXIS_COUNT; a++) begin
            if (in_item.axis_index == AXIS_W'(a)) begin
               inc_mem[a][tail_ff] <= {1'b0, in_item.axis_delta};
               acc_mem[a][tail_ff] <= in_item.axis_error;
            end
         end
      end
      if (fire && in_item.operation == OP_TICK) begin
         for (int a = 0; a < AXIS_COUNT; a++) begin
            if (acc_we[a]) acc_mem[a][slot] <= acc_new[a];
         end
      end
   end

`include "multi_axis_bresenham_step_generator_top_assert.svh"
   `MBSG_NEVER(a_count_range, count_ff > CNT_W'(QUEUE_DEPTH), "queue count overflow")
   `MBSG_NEVER(a_active_counted, active_ff && count_ff == '0, "active segment not counted")
   `MBSG_ASSERT(a_empty_ptrs, count_ff == '0 |-> head_ff == tail_ff, "empty ring with split ptrs")
   `MBSG_ASSERT(a_parent_done, out_valid_ff && out_ff.parent_done |-> out_ff.segment_done,
                "parent done without segment done")

endmodule

// ===== rtl/core/multi_axis_bresenham_step_generator_top.sv =====
// Top level of the multi-axis Bresenham step generator.
// Every request beat (step tick, header commit or axis word) yields exactly one
// response beat, in order. Beats pass a two-entry input queue (front) into the
// executor (back), which handles one beat per clock: a new beat is taken every
// cycle as long as the response register is free or being drained, so the
// sustained rate is one item per cycle. Each beat is registered in the front
// queue, its response in the response register. The executor holds a 16-slot
// ring of segments; a tick adds every unblocked axis increment to its
// accumulator in parallel: one 32-bit add, a sign test and an error-step
// subtract per axis, which sets the cycle time. Load axis words (then the
// header) into the tail slot before ticking. No clearing pass after reset.
// Register 0 (byte address 0): bit 0 dir_wait, 1 holds off stepping for one
// tick after a direction change.
module multi_axis_bresenham_step_generator_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata: axis_mask[6:0] directions[13:7] check_endstops[14] parent_id[22:15]
   //        step_count[38:23] secondary_value[46:39] axis_index[49:47]
   //        axis_delta[80:50] axis_error[112:81] skip_request[113]
   input  logic [119:0]  req_tdata,
   // tuser: operation[1:0]
   input  logic [1:0]    req_tuser,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata: step_mask[6:0] direction_mask[13:7] direction_changed[14]
   //        secondary_update[15] secondary_out[23:16] segment_done[24]
   //        parent_done[25] idle[26] queue_level[31:27] load_rejected[32]
   output logic [39:0]   rsp_tdata,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [0:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import mbsg_pkg::*;

   req_item_type req_item, q_item;
   rsp_item_type rsp_item;
   logic         q_valid, q_ready;
   logic         slow_dir_ff;

   // unpack request beat
   always_comb begin
      req_item.operation       = op_type'(req_tuser);
      req_item.axis_mask       = req_tdata[6:0];
      req_item.directions      = req_tdata[13:7];
      req_item.check_endstops  = req_tdata[14];
      req_item.last_of_parent  = req_tlast;
      req_item.parent_id       = req_tdata[22:15];
      req_item.step_count      = req_tdata[38:23];
      req_item.secondary_value = req_tdata[46:39];
      req_item.axis_index      = req_tdata[49:47];
      req_item.axis_delta      = req_tdata[80:50];
      req_item.axis_error      = req_tdata[112:81];
      req_item.skip_request    = req_tdata[113];
   end

   assign rsp_tdata = {7'd0, rsp_item.load_rejected, rsp_item.queue_level, rsp_item.idle,
                       rsp_item.parent_done, rsp_item.segment_done, rsp_item.secondary_out,
                       rsp_item.secondary_update, rsp_item.direction_changed,
                       rsp_item.direction_mask, rsp_item.step_mask};

   // config register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_SLOW_DIR) ? {31'd0, slow_dir_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_dir_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == CSR_SLOW_DIR) begin
         slow_dir_ff <= csr_pwdata[0];
      end
   end

   mbsg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   mbsg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .slow_dir  (slow_dir_ff),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

endmodule

// ===== sim/mbsg_step_checker.sv =====
// Watches the request, response and register ports of the step generator and checks beats.
module mbsg_step_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [119:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [0:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending_count
);
   import mbsg_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int AXES  = AXIS_COUNT;

   // mirrored ring and control state
   logic [6:0]  ring_dirs [DEPTH];
   logic [6:0]  ring_used [DEPTH];
   logic [1:0]  ring_flags [DEPTH];
   logic [7:0]  ring_parent [DEPTH];
   logic [15:0] ring_left [DEPTH];
   logic [7:0]  ring_intensity [DEPTH];
   logic [31:0] ring_err_step [DEPTH];
   logic [31:0] axis_inc [DEPTH*AXES];
   logic [31:0] axis_acc [DEPTH*AXES];
   int          head, tail, level;
   bit          running;
   logic [7:0]  cur_dirs, cur_parent, skipped_parent;
   logic [6:0]  blocked;
   bit          slow_dir;

   rsp_item_type out_beat;
   rsp_item_type step_results [$];
   int           fails;

   assign fail_count = fails;

   function automatic bit activate_head();
      int s;
      bit nd;
      s  = head;
      nd = (cur_dirs != {1'b0, ring_dirs[s]}) && (ring_used[s] != 0);
      head = (head + 1) % DEPTH;
      running = 1;
      if (ring_parent[s] != cur_parent) begin
         blocked = '0;
         skipped_parent = PARENT_NONE;
      end
      if (nd) begin
         cur_dirs = {1'b0, ring_dirs[s]};
         out_beat.direction_changed = 1'b1;
      end
      cur_parent = ring_parent[s];
      out_beat.secondary_update = 1'b1;
      out_beat.secondary_out = ring_intensity[s];
      return nd;
   endfunction

   function automatic void retire(int s);
      out_beat.segment_done = 1'b1;
      if (ring_flags[s][1]) out_beat.parent_done = 1'b1;
      if (level > 0) level--;
   endfunction

   function automatic void advance_axes(int s, logic [6:0] blk);
      logic [31:0] e;
      int k;
      for (int a = 0; a < AXES; a++) begin
         k = s*AXES + a;
         if (!blk[a]) begin
            e = axis_acc[k] + axis_inc[k];
            if (e != 0 && !e[31]) begin
               out_beat.step_mask[a] = 1'b1;
               e = e - ring_err_step[s];
            end
            axis_acc[k] = e;
         end
      end
   endfunction

   function automatic void step_tick(logic [6:0] hit_mask, logic skip);
      int s;
      if (!running) begin
         if (level == 0) return;
         if (activate_head() && slow_dir) return;
      end
      s = (head == 0) ? DEPTH-1 : head-1;
      if (ring_used[s] != 0) begin
         if (ring_flags[s][0]) begin
            if (ring_parent[s] == skipped_parent) begin
               retire(s);
               if (level == 0) running = 0;
               else void'(activate_head());
               return;
            end
            if (skip) begin
               skipped_parent = ring_parent[s];
               return;
            end
            blocked = blocked | hit_mask;
            advance_axes(s, blocked);
         end else begin
            advance_axes(s, '0);
         end
      end
      ring_left[s] = ring_left[s] - 16'd1;
      if (ring_left[s] == 0) begin
         retire(s);
         running = 0;
      end
   endfunction

   function automatic void predict_beat(logic [1:0] op, logic [119:0] d, logic lst);
      int t;
      logic [2:0] ax;
      out_beat = '0;
      t = tail;
      ax = d[49:47];
      if (op == OP_TICK) begin
         step_tick(d[6:0], d[113]);
      end else if (op == OP_COMMIT) begin
         if (level >= DEPTH) begin
            out_beat.load_rejected = 1'b1;
         end else begin
            ring_used[t]      = d[6:0];
            ring_dirs[t]      = d[13:7];
            ring_flags[t]     = {lst, d[14]};
            ring_parent[t]    = d[22:15];
            ring_left[t]      = d[38:23];
            ring_intensity[t] = d[46:39];
            tail = (t + 1) % DEPTH;
            level++;
         end
      end else if (op == OP_LOAD) begin
         if (level < DEPTH) begin
            if (ax == ERROR_STEP_SEL) ring_err_step[t] = {1'b0, d[80:50]};
            else if (ax < AXES) begin
               axis_inc[t*AXES + ax] = {1'b0, d[80:50]};
               axis_acc[t*AXES + ax] = d[112:81];
            end
         end
      end
      out_beat.direction_mask = cur_dirs[6:0];
      out_beat.idle = (!running && level == 0);
      out_beat.queue_level = level[4:0];
      step_results.push_back(out_beat);
   endfunction

   function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         fails++;
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp, act);
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type exp;
      if (reset) begin
         head = 0; tail = 0; level = 0; running = 0;
         cur_dirs = LAST_DIRS_RESET; cur_parent = PARENT_NONE;
         skipped_parent = PARENT_NONE; blocked = '0; slow_dir = 0;
         step_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (step_results.size() == 0) begin
               fails++;
               $display("%0t unexpected response beat: expected none actual %0h",
                        $time, rsp_tdata);
            end else begin
               exp = step_results.pop_front();
               check_field("step_mask", 32'(exp.step_mask), 32'(rsp_tdata[6:0]));
               check_field("direction_mask", 32'(exp.direction_mask),
                           32'(rsp_tdata[13:7]));
               check_field("direction_changed", 32'(exp.direction_changed),
                           32'(rsp_tdata[14]));
               check_field("secondary_update", 32'(exp.secondary_update),
                           32'(rsp_tdata[15]));
               check_field("secondary_out", 32'(exp.secondary_out), 32'(rsp_tdata[23:16]));
               check_field("segment_done", 32'(exp.segment_done), 32'(rsp_tdata[24]));
               check_field("parent_done", 32'(exp.parent_done), 32'(rsp_tdata[25]));
               check_field("idle", 32'(exp.idle), 32'(rsp_tdata[26]));
               check_field("queue_level", 32'(exp.queue_level), 32'(rsp_tdata[31:27]));
               check_field("load_rejected", 32'(exp.load_rejected), 32'(rsp_tdata[32]));
            end
         end
         if (req_tvalid && req_tready) predict_beat(req_tuser, req_tdata, req_tlast);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CSR_SLOW_DIR)
            slow_dir = csr_pwdata[0];
      end
      pending_count <= step_results.size();
   end

endmodule

// ===== sim/tb_multi_axis_bresenham_step_generator_top.sv =====
// Stimulus and verdict for the step generator, with the checker beside the block.
module tb_multi_axis_bresenham_step_generator_top;
   import mbsg_pkg::*;

   localparam logic [1:0] OP_UNKNOWN  = 2'd3;
   localparam int         PHASE_BEATS = 425;

   logic         clock;
   logic         reset;
   logic         req_tvalid, req_tready, req_tlast;
   logic [119:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid, rsp_tready;
   logic [39:0]  rsp_tdata;
   logic         csr_psel, csr_penable, csr_pwrite;
   logic [0:0]   csr_paddr;
   logic [31:0]  csr_pwdata, csr_prdata;
   logic         csr_pready;
   int           fail_count, pending_count;
   int           burst_left;
   int           beats_sent;

   multi_axis_bresenham_step_generator_top u_dut (.*);

   mbsg_step_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_psel, .csr_penable, .csr_pwrite,
      .csr_paddr, .csr_pwdata, .csr_pready, .fail_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver stall pattern: at each wrap of the stall counter pick free-running, coin-flip or mostly-stalled.
   int stall_mode = 0;
   int stall_cnt  = 0;
   always @(posedge clock) begin
      if (stall_cnt == 0) stall_mode <= $urandom_range(0, 2);
      stall_cnt <= (stall_cnt + 1) % 64;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Limit: far beyond the slowest legal run.
   initial begin
      #(20 * 400000);
      $display("tb_multi_axis_bresenham_step_generator_top NOT OK");
      $finish;
   end

   // One beat on the request channel; bursts with random gaps between them.
   task automatic send_beat(input logic [1:0] op, input logic [119:0] d, input logic lst);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= op;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      beats_sent++;
   endtask

   function automatic logic [119:0] rand_bits();
      return 120'({$urandom, $urandom, $urandom, $urandom});
   endfunction

   // Tick: mask and skip are live, the rest of the beat is junk.
   task automatic send_tick(input logic [6:0] hit, input logic skip);
      logic [119:0] d;
      d = rand_bits();
      d[6:0] = hit;
      d[113] = skip;
      send_beat(OP_TICK, d, 1'($urandom_range(0, 1)));
   endtask

   // All seven axis words plus the error step in random order, then the header.
   // Sent with no ticks in between, so the ring cannot drain mid-segment.
   task automatic load_segment(input logic [6:0] used, input logic [6:0] dirs,
                               input logic chk, input logic lst, input logic [7:0] par,
                               input logic [15:0] steps, input logic [7:0] sec,
                               input bit extreme);
      logic [2:0]   order [8];
      logic [2:0]   tmp;
      logic [119:0] d;
      int           j;
      for (int i = 0; i < 8; i++) order[i] = 3'(i);
      for (int i = 7; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      for (int i = 0; i < 8; i++) begin
         d = rand_bits();
         d[49:47] = order[i];
         if (extreme) begin
            d[80:50]  = 31'h7fffffff;
            d[112:81] = 32'h80000000;
         end else if ($urandom_range(0, 1)) begin
            d[80:50]  = 31'($urandom_range(0, 100));
            d[112:81] = $urandom_range(0, 200) - 100;
         end
         send_beat(OP_LOAD, d, 1'($urandom_range(0, 1)));
      end
      d = rand_bits();
      d[6:0]   = used;
      d[13:7]  = dirs;
      d[14]    = chk;
      d[22:15] = par;
      d[38:23] = steps;
      d[46:39] = sec;
      send_beat(OP_COMMIT, d, lst);
   endtask

   task automatic csr_write(input logic [31:0] v);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= CSR_SLOW_DIR;
      csr_pwdata <= v; csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // Drain all outstanding responses before touching the register.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic random_segment();
      logic [6:0]  used;
      logic        chk;
      logic [7:0]  par;
      logic [15:0] steps;
      used  = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom);
      chk   = 1'($urandom_range(0, 1));
      par   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 254))
                                          : 8'($urandom_range(0, 3));
      steps = 16'($urandom_range(1, 10));
      // long or wrapping segments only where a skip request can cut them short
      if (chk && used != 0 && $urandom_range(0, 6) == 0) steps = 16'($urandom);
      load_segment(used, 7'($urandom), chk, 1'($urandom_range(0, 1)), par, steps,
                   8'($urandom), 1'b0);
   endtask

   initial begin
      int seg_pct [4];
      int phase_end;
      int roll;
      seg_pct = '{40, 70, 40, 25};
      reset <= 1'b1;
      req_tvalid <= 1'b0; req_tdata <= '0; req_tuser <= OP_TICK; req_tlast <= 1'b0;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= '0;
      burst_left = 0; beats_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      csr_write(32'd0);
      // wrapping count, checked, extreme deltas; then skip it and its sibling
      load_segment(7'h7f, 7'h7f, 1'b1, 1'b0, 8'd0, 16'd0, 8'hff, 1'b1);
      load_segment(7'h55, 7'h2a, 1'b1, 1'b1, 8'd0, 16'hffff, 8'h00, 1'b0);
      send_tick(7'h00, 1'b0);   // activate, directions change
      send_tick(7'h41, 1'b0);   // block two axes
      send_tick(7'h00, 1'b1);   // endstop hit: skip parent
      send_tick(7'h00, 1'b0);   // both segments of the parent retire, one per tick
      send_tick(7'h00, 1'b0);
      send_beat(OP_UNKNOWN, rand_bits(), 1'b0);
      // no used axes: only counts down
      load_segment(7'h00, 7'h00, 1'b0, 1'b1, 8'd254, 16'd2, 8'h80, 1'b0);
      repeat (4) send_tick(7'h7f, 1'b1);

      // --- random phases, register toggled between them ---
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         csr_write({31'($urandom), ph[0] ? 1'b1 : 1'b0});
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) begin
            roll = $urandom_range(0, 99);
            if (roll < seg_pct[ph]) begin
               random_segment();
            end else if (roll < 95) begin
               repeat ($urandom_range(1, 6))
                  send_tick(($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'd0,
                            ($urandom_range(0, 24) == 0));
            end else begin
               send_beat(OP_UNKNOWN, rand_bits(), 1'($urandom_range(0, 1)));
            end
         end
      end

      drain();
      if (fail_count == 0)
         $display("tb_multi_axis_bresenham_step_generator_top OK");
      else
         $display("tb_multi_axis_bresenham_step_generator_top NOT OK");
      $finish;
   end

endmodule
